// ----- rtl/ipv4dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4dtp_pkg
// Types, character codes and the per-character scan step of the IPv4 text
// parser.
// ----------------------------------------------------------------------------
package ipv4dtp_pkg;

  localparam logic [8:0] OctetLimit = 9'd256;
  localparam int unsigned ClassShift = 6;
  localparam int unsigned NumParts = 4;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;

  localparam logic [4:0] NoDigit = 5'd16;
  localparam logic [4:0] Base8   = 5'd8;
  localparam logic [4:0] Base10  = 5'd10;
  localparam logic [4:0] Base16  = 5'd16;

  typedef enum logic [8:0] {
    M_START = 9'b000000001,
    M_SPACE = 9'b000000010,
    M_SIGN  = 9'b000000100,
    M_ZERO  = 9'b000001000,
    M_XPRE  = 9'b000010000,
    M_HEX   = 9'b000100000,
    M_OCT   = 9'b001000000,
    M_DEC   = 9'b010000000,
    M_DONE  = 9'b100000000
  } scan_mode_e;

  typedef struct packed {
    logic [2:0] part_count;
    scan_mode_e mode;
    logic [7:0] part_value;
    logic       too_big;
    logic       minus;
    logic       reject;
  } ctrl_t;

  typedef struct packed {
    ctrl_t           ctrl;
    logic [3:0][7:0] octets;
  } parse_t;

  localparam ctrl_t CtrlReset = '{
    part_count: 3'd0,
    mode:       M_START,
    part_value: 8'd0,
    too_big:    1'b0,
    minus:      1'b0,
    reject:     1'b0
  };

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    if (c >= ChZero && c <= ChNine) begin
      d = 5'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowF) begin
      d = 5'(c - ChLowA) + 5'd10;
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = 5'(c - ChUpA) + 5'd10;
    end else begin
      d = NoDigit;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  // part_value = part_value * base + d, saturating at 255 with a flag
  function automatic parse_t add_digit(input parse_t s, input logic [4:0] base,
                                       input logic [4:0] d);
    parse_t     r;
    logic [12:0] v;
    r = s;
    if (base == Base16) begin
      v = {1'b0, s.ctrl.part_value, 4'd0};
    end else if (base == Base8) begin
      v = {2'b0, s.ctrl.part_value, 3'd0};
    end else begin
      v = {2'b0, s.ctrl.part_value, 3'd0} + {4'b0, s.ctrl.part_value, 1'b0};
    end
    v = v + 13'(d);
    if (v >= 13'(OctetLimit)) begin
      r.ctrl.too_big    = 1'b1;
      r.ctrl.part_value = 8'hFF;
    end else begin
      r.ctrl.part_value = v[7:0];
    end
    return r;
  endfunction

  function automatic parse_t finish_part(input parse_t s, input logic at_end);
    parse_t r;
    r = s;
    if (s.ctrl.too_big || (s.ctrl.minus && s.ctrl.part_value != 8'd0) ||
        s.ctrl.part_count >= 3'(NumParts)) begin
      r.ctrl.reject = 1'b1;
      r.ctrl.mode   = M_DONE;
    end else begin
      r.octets[s.ctrl.part_count[1:0]] = s.ctrl.part_value;
      r.ctrl.part_count = s.ctrl.part_count + 3'd1;
      if (at_end || r.ctrl.part_count == 3'(NumParts)) begin
        r.ctrl.mode = M_DONE;
      end else begin
        r.ctrl.mode       = M_START;
        r.ctrl.part_value = 8'd0;
        r.ctrl.too_big    = 1'b0;
        r.ctrl.minus      = 1'b0;
      end
    end
    return r;
  endfunction

  // One character through the scanner
  function automatic parse_t feed(input parse_t s, input logic [7:0] c);
    parse_t     r;
    logic       is_dec;
    logic       term;
    logic [4:0] d;
    logic [4:0] base;
    r      = s;
    is_dec = (c >= ChZero && c <= ChNine);
    term   = (c == ChDot) || (c == ChNul);
    d      = digit_of(c);
    base   = Base10;
    if (!s.ctrl.reject && s.ctrl.mode != M_DONE) begin
      unique case (s.ctrl.mode) inside
        M_START, M_SPACE: begin
          if (s.ctrl.mode == M_START && c == ChNul) begin
            r.ctrl.mode = M_DONE;
          end else if (s.ctrl.mode == M_START && c == ChDot) begin
            r = finish_part(s, 1'b0);
          end else if (is_space(c)) begin
            r.ctrl.mode = M_SPACE;
          end else if (c == ChPlus || c == ChMinus) begin
            r.ctrl.minus = (c == ChMinus);
            r.ctrl.mode  = M_SIGN;
          end else if (is_dec) begin
            r.ctrl.mode       = (c == ChZero) ? M_ZERO : M_DEC;
            r.ctrl.part_value = c - ChZero;
          end else begin
            r.ctrl.reject = 1'b1;
            r.ctrl.mode   = M_DONE;
          end
        end
        M_SIGN: begin
          if (is_dec) begin
            r.ctrl.mode       = (c == ChZero) ? M_ZERO : M_DEC;
            r.ctrl.part_value = c - ChZero;
          end else begin
            r.ctrl.reject = 1'b1;
            r.ctrl.mode   = M_DONE;
          end
        end
        M_ZERO: begin
          if (c == ChLowX || c == ChUpX) begin
            r.ctrl.mode = M_XPRE;
          end else if (c >= ChZero && c <= ChSeven) begin
            r = add_digit(s, Base8, d);
            r.ctrl.mode = M_OCT;
          end else if (term) begin
            r = finish_part(s, c == ChNul);
          end else begin
            r.ctrl.reject = 1'b1;
            r.ctrl.mode   = M_DONE;
          end
        end
        M_XPRE: begin
          if (d < NoDigit) begin
            r = add_digit(s, Base16, d);
            r.ctrl.mode = M_HEX;
          end else begin
            r.ctrl.reject = 1'b1;
            r.ctrl.mode   = M_DONE;
          end
        end
        M_HEX, M_OCT, M_DEC: begin
          if (s.ctrl.mode == M_HEX) begin
            base = Base16;
          end else if (s.ctrl.mode == M_OCT) begin
            base = Base8;
          end
          if (d < base) begin
            r = add_digit(s, base, d);
          end else if (term) begin
            r = finish_part(s, c == ChNul);
          end else begin
            r.ctrl.reject = 1'b1;
            r.ctrl.mode   = M_DONE;
          end
        end
        default: begin
          r.ctrl.reject = 1'b1;
          r.ctrl.mode   = M_DONE;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/ipv4_dotted_text_parser_top.sv -----
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser_top
// Character-serial parser of IPv4 dotted text (C-style parts, classful
// shorthand) giving a valid flag and a 32-bit address per text.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------
//  in      | sink      | in_valid_i / in_stall_o | char_code_i[7:0], last_char_i
//  out     | source    | out_valid_o / out_stall_i | addr_valid_o, address_o[31:0]
//
//  One character per cycle: the scan state register is updated by one pass of
//  the character step (two passes on the final character, the second with a
//  zero byte to close the text), so a transaction can be taken every cycle
//  while in_stall_o is low. The last character's result lands in the output
//  register in the cycle after acceptance; only the final character gives an
//  out transaction. Reset (asynchronous, active low) clears the scan state and
//  the output valid; the octet store and output payload are not reset.
//  The input stalls only while a result is held in the output register and
//  the sink stalls it; the output register alone decouples the two sides.
//
module ipv4_dotted_text_parser_top
  import ipv4dtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        addr_valid_o,
  output logic [31:0] address_o
);

  // scan state: control part is reset, octet store is not
  ctrl_t           ctrl_q, ctrl_d;
  logic [3:0][7:0] octets_q, octets_d;

  logic        out_valid_q, out_valid_d;
  logic        addr_valid_q, addr_valid_d;
  logic [31:0] address_q, address_d;

  logic   in_accept;
  parse_t cur;
  parse_t step1;
  parse_t step2;
  logic   ok;
  logic [1:0] cls;
  logic [3:0][7:0] o;

  // a stalled result blocks input; otherwise the output slot frees this edge
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign cur.ctrl   = ctrl_q;
  assign cur.octets = octets_q;

  // character step, then the closing zero byte on the final character
  assign step1 = feed(cur, char_code_i);
  assign step2 = feed(step1, ChNul);

  // classful shorthand: assemble octets by part count and first-octet class
  always_comb begin
    cls = step2.octets[0][7:ClassShift];
    o   = '0;
    ok  = !step2.ctrl.reject && step2.ctrl.part_count != 3'd0;
    if (ok) begin
      o[3] = step2.octets[0];
      if (step2.ctrl.part_count == 3'(NumParts)) begin
        o[2] = step2.octets[1];
        o[1] = step2.octets[2];
        o[0] = step2.octets[3];
      end else if (cls <= 2'd1 && step2.ctrl.part_count == 3'd3) begin
        o[1] = step2.octets[1];
        o[0] = step2.octets[2];
      end else if (cls <= 2'd1 && step2.ctrl.part_count == 3'd2) begin
        o[0] = step2.octets[1];
      end else if (cls == 2'd2 && step2.ctrl.part_count == 3'd3) begin
        o[2] = step2.octets[1];
        o[0] = step2.octets[2];
      end else begin
        ok = 1'b0;
      end
    end
  end

  always_comb begin
    ctrl_d       = ctrl_q;
    octets_d     = octets_q;
    out_valid_d  = out_valid_q & out_stall_i;
    addr_valid_d = addr_valid_q;
    address_d    = address_q;
    if (in_accept) begin
      if (last_char_i) begin
        // text closed: result out, scan control back to its reset value
        ctrl_d       = CtrlReset;
        octets_d     = step2.octets;
        out_valid_d  = 1'b1;
        addr_valid_d = ok;
        address_d    = ok ? o : 32'd0;
      end else begin
        ctrl_d   = step1.ctrl;
        octets_d = step1.octets;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= CtrlReset;
      out_valid_q <= 1'b0;
    end else begin
      ctrl_q      <= ctrl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    octets_q     <= octets_d;
    addr_valid_q <= addr_valid_d;
    address_q    <= address_d;
  end

  assign out_valid_o  = out_valid_q;
  assign addr_valid_o = addr_valid_q;
  assign address_o    = address_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.part_count <= 3'(NumParts))
    else $error("part count beyond four");

  a_reject_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.reject |-> ctrl_q.mode == M_DONE)
    else $error("rejected text not parked in done mode");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_char_i |=> out_valid_o && ctrl_q == CtrlReset)
    else $error("final character did not give a result and clear the scan");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !addr_valid_o |-> address_o == 32'd0)
    else $error("rejected text with non-zero address");

endmodule

// ----- tb/tb_ipv4_dotted_text_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_text_parser_top
// Self-checking bench for the character-serial IPv4 dotted text parser. Texts
// are queued up front: a short run of corner texts, then mostly well-formed
// random addresses in decimal, octal and hex with occasional noise. A local
// scanner predicts each text's verdict and address when its last character
// goes in, and the monitor checks every result transaction against it.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_text_parser_top
  import ipv4dtp_pkg::*;
;

  localparam int CycleLimit   = 300000;
  localparam int LongHold     = 300;   // cycles the sink holds off once
  localparam int TargetChars  = 850;
  localparam int MinTexts     = 60;

  // One character transaction as queued for the driver. drain asks the
  // driver to hold this character back until every queued result is in.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       drain;
  } char_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } parsed_addr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = 8'd0;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        addr_valid_o;
  logic [31:0] address_o;

  ipv4_dotted_text_parser_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .addr_valid_o (addr_valid_o),
    .address_o    (address_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Stores and counters
  // --------------------------------------------------------------------------
  char_item_t   char_q[$];        // characters still to be driven
  parsed_addr_t addr_expect_q[$]; // predicted results, oldest first
  logic [7:0]   text_buf[$];      // text under construction

  logic drain_next    = 1'b0;
  logic in_taken      = 1'b0;     // input transaction at the last rising edge
  logic drained       = 1'b0;
  logic hold_off_done = 1'b0;
  int   queued_chars  = 0;
  int   queued_texts  = 0;
  int   chars_taken   = 0;
  int   texts_checked = 0;
  int   accepted_addrs = 0;
  int   mismatches    = 0;
  int   cycles        = 0;

  // --------------------------------------------------------------------------
  // Address scanner: mirrors the block's behaviour one character at a time
  // --------------------------------------------------------------------------
  scan_mode_e pmode = M_START;
  logic [2:0] pcount = 3'd0;
  logic [7:0] pval = 8'd0;
  logic       ptoo_big = 1'b0;
  logic       pminus = 1'b0;
  logic       preject = 1'b0;
  logic [7:0] poctet[4] = '{default: 8'd0};

  function automatic int unsigned digit_val(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return c - ChZero;
    if (c >= ChLowA && c <= ChLowF) return c - ChLowA + 10;
    if (c >= ChUpA && c <= ChUpF) return c - ChUpA + 10;
    return 16;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  task automatic new_part();
    pmode    = M_START;
    pval     = 8'd0;
    ptoo_big = 1'b0;
    pminus   = 1'b0;
  endtask

  task automatic clear_text();
    pcount  = 3'd0;
    preject = 1'b0;
    new_part();
  endtask

  // value = value * base + digit, pinned at 255 once it overflows
  task automatic accumulate(input int unsigned base, input int unsigned d);
    int unsigned v;
    v = pval * base + d;
    if (v >= 256) begin
      ptoo_big = 1'b1;
      v = 255;
    end
    pval = 8'(v);
  endtask

  task automatic close_part(input logic at_end);
    if (ptoo_big || (pminus && pval != 8'd0) || pcount >= 3'd4) begin
      preject = 1'b1;
      pmode   = M_DONE;
    end else begin
      poctet[pcount[1:0]] = pval;
      pcount = pcount + 3'd1;
      if (at_end || pcount == 3'd4) begin
        pmode = M_DONE;
      end else begin
        new_part();
      end
    end
  endtask

  task automatic first_digit(input logic [7:0] c);
    if (c == ChZero) begin
      pmode = M_ZERO;
    end else begin
      pmode = M_DEC;
    end
    pval = c - ChZero;
  endtask

  task automatic scan_char(input logic [7:0] c);
    int unsigned d;
    int unsigned base;
    logic        dec;
    logic        term;
    logic        bad;
    d    = digit_val(c);
    dec  = (c >= ChZero && c <= ChNine);
    term = (c == ChDot) || (c == ChNul);
    bad  = 1'b0;
    if (preject || pmode == M_DONE) return;
    case (pmode)
      M_START, M_SPACE: begin
        if (pmode == M_START && c == ChNul) begin
          pmode = M_DONE;
        end else if (pmode == M_START && c == ChDot) begin
          close_part(1'b0);           // empty part counts as zero
        end else if (is_blank(c)) begin
          pmode = M_SPACE;
        end else if (c == ChPlus || c == ChMinus) begin
          pminus = (c == ChMinus);
          pmode  = M_SIGN;
        end else if (dec) begin
          first_digit(c);
        end else begin
          bad = 1'b1;
        end
      end
      M_SIGN: begin
        if (dec) begin
          first_digit(c);
        end else begin
          bad = 1'b1;
        end
      end
      M_ZERO: begin
        if (c == ChLowX || c == ChUpX) begin
          pmode = M_XPRE;
        end else if (c >= ChZero && c <= ChSeven) begin
          pmode = M_OCT;
          accumulate(8, d);
        end else if (term) begin
          close_part(c == ChNul);
        end else begin
          bad = 1'b1;
        end
      end
      M_XPRE: begin
        if (d < 16) begin
          pmode = M_HEX;
          accumulate(16, d);
        end else begin
          bad = 1'b1;
        end
      end
      M_HEX, M_OCT, M_DEC: begin
        if (pmode == M_HEX) begin
          base = 16;
        end else if (pmode == M_OCT) begin
          base = 8;
        end else begin
          base = 10;
        end
        if (d < base) begin
          accumulate(base, d);
        end else if (term) begin
          close_part(c == ChNul);
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      preject = 1'b1;
      pmode   = M_DONE;
    end
  endtask

  // Feeds one accepted character; on the last one closes the text with a
  // zero byte and queues the expected verdict and address.
  task automatic predict_char(input logic [7:0] c, input logic last);
    parsed_addr_t res;
    logic [7:0]   b1;
    logic [7:0]   b2;
    logic [7:0]   b3;
    logic [1:0]   cls;
    scan_char(c);
    if (!last) return;
    scan_char(ChNul);
    b1  = 8'd0;
    b2  = 8'd0;
    b3  = 8'd0;
    cls = poctet[0][7:6];
    res.ok = !preject && pcount >= 3'd1 && pcount <= 3'd4;
    if (res.ok) begin
      if (pcount == 3'd4) begin
        b1 = poctet[1];
        b2 = poctet[2];
        b3 = poctet[3];
      end else if (cls <= 2'd1 && pcount == 3'd3) begin
        b2 = poctet[1];
        b3 = poctet[2];
      end else if (cls <= 2'd1 && pcount == 3'd2) begin
        b3 = poctet[1];
      end else if (cls == 2'd2 && pcount == 3'd3) begin
        b1 = poctet[1];
        b3 = poctet[2];
      end else begin
        res.ok = 1'b0;  // short form not allowed for this class, or one part
      end
    end
    res.addr = res.ok ? {poctet[0], b1, b2, b3} : 32'd0;
    addr_expect_q.push_back(res);
    clear_text();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last);
    char_item_t it;
    it.code  = c;
    it.last  = last;
    it.drain = drain_next;
    drain_next = 1'b0;
    char_q.push_back(it);
    queued_chars++;
  endtask

  task automatic append_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Sends text_buf as one text, last mark on its final character
  task automatic flush_text();
    if (text_buf.size() == 0) text_buf.push_back(ChNul);
    foreach (text_buf[i]) push_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
    queued_texts++;
  endtask

  task automatic append_part();
    int unsigned v;
    int          r;
    string       digits;
    if ($urandom_range(0, 19) == 0) return;  // empty part
    v = ($urandom_range(0, 11) == 0) ? $urandom_range(256, 4095) : $urandom_range(0, 255);
    if ($urandom_range(0, 11) == 0) begin
      r = $urandom_range(8, 13);
      text_buf.push_back((r == 8) ? ChSpace : 8'(r));
    end
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1)) begin
        text_buf.push_back(ChMinus);
        if ($urandom_range(0, 1)) v = 0;
      end else begin
        text_buf.push_back(ChPlus);
      end
    end
    r = $urandom_range(0, 9);
    if (r < 6) begin
      digits = $sformatf("%0d", v);
    end else if (r < 8) begin
      digits = $sformatf("%0h", v);
      if ($urandom_range(0, 1)) digits = digits.toupper();
      if ($urandom_range(0, 1)) begin
        digits = {"0x", digits};
      end else begin
        digits = {"0X", digits};
      end
    end else begin
      digits = $sformatf("0%0o", v);
    end
    append_str(digits);
    if ($urandom_range(0, 24) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_random_text();
    int r;
    int parts;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      parts = 4;
    end else if (r < 7) begin
      parts = 3;
    end else if (r < 9) begin
      parts = 2;
    end else begin
      parts = $urandom_range(0, 1) ? 1 : 5;
    end
    for (int p = 0; p < parts; p++) begin
      if (p > 0) text_buf.push_back(ChDot);
      append_part();
    end
    if ($urandom_range(0, 9) == 0) text_buf.push_back(ChDot);
    if (parts >= 4 && $urandom_range(0, 3) == 0) begin
      // tail after the fourth part, ignored once a dot closes it
      text_buf.push_back(ChDot);
      repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      text_buf.push_back(ChNul);
      repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
    flush_text();
  endtask

  task automatic push_noise();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) push_char(8'($urandom_range(0, 255)), i == len - 1);
    queued_texts++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: changes on the falling edge, holds a stalled transaction
  // --------------------------------------------------------------------------
  int         send_gap  = 0;
  logic       send_calm = 1'b0;
  char_item_t send_item;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (char_q.size() > 0 && !(char_q[0].drain && addr_expect_q.size() > 0)) begin
        send_item   = char_q.pop_front();
        char_code_i <= send_item.code;
        last_char_i <= send_item.last;
        in_valid_i  <= 1'b1;
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output sink: random stalls, plus one long hold-off that backs the block
  // up until it stalls its input while the driver keeps offering characters
  // --------------------------------------------------------------------------
  int   sink_wait = 0;
  logic sink_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_off_done && texts_checked >= 25) begin
        hold_off_done = 1'b1;
        sink_wait     = LongHold;
      end
      if (sink_wait > 0) begin
        out_stall_i <= 1'b1;
        sink_wait--;
      end else begin
        if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
        sink_wait = pick_gap(sink_calm);
        out_stall_i <= (sink_wait > 0);
        if (sink_wait > 0) sink_wait--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge, predicts on input
  // transactions and checks output transactions in order
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    parsed_addr_t want;
    cycles++;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      chars_taken++;
      predict_char(char_code_i, last_char_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      texts_checked++;
      if (addr_expect_q.size() == 0) begin
        $error("result with no text pending: addr_valid %0b address %08h",
               addr_valid_o, address_o);
        mismatches++;
      end else begin
        want = addr_expect_q.pop_front();
        if (want.ok) accepted_addrs++;
        if (addr_valid_o !== want.ok) begin
          $error("addr_valid mismatch: expected %0b, got %0b", want.ok, addr_valid_o);
          mismatches++;
        end
        if (address_o !== want.addr) begin
          $error("address mismatch: expected %08h, got %08h", want.addr, address_o);
          mismatches++;
        end
      end
    end
    drained = rst_ni && char_q.size() == 0 && !in_valid_i && addr_expect_q.size() == 0;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, addr_expect_q.size());
      $display("ipv4_dotted_text_parser_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: queue all stimulus, reset, then wait for the run to drain
  // --------------------------------------------------------------------------
  initial begin
    string corner_texts[$];
    corner_texts = '{
      "255.255.255.255",  // top of every octet
      "0x7f.1",           // hex, class A two-part short form
      "0177.0.1",         // octal, class A three parts
      "128.1.2",          // class B three parts
      "200.1",            // class C short form, rejected
      "7",                // single part, rejected
      ".1.2",             // leading empty part
      "1.2.",             // trailing dot
      " \t-0.+9",         // whitespace, minus with zero, plus
      "-1.2",             // minus with non-zero magnitude
      " +",               // sign with no digit
      "+ 1",              // whitespace after sign
      "0x.1",             // hex prefix with no digit
      "09",               // octal part hits 9
      "1a",               // bad terminator
      "256.1",            // octet overflow
      "1.2.3.4.zz",       // text beyond fourth part ignored
      "0X1F.0Xa"          // upper-case hex prefix
    };
    foreach (corner_texts[i]) begin
      append_str(corner_texts[i]);
      flush_text();
    end
    // zero byte ends the text early
    append_str("1.2");
    text_buf.push_back(ChNul);
    text_buf.push_back("q");
    flush_text();
    push_char(ChNul, 1'b1);   // empty text
    queued_texts++;
    push_char(8'hFF, 1'b1);   // top character code
    queued_texts++;

    while (queued_chars < TargetChars || queued_texts < MinTexts) begin
      // driver waits for an empty pipe before these two texts
      if (queued_texts == 40 || queued_texts == 75) drain_next = 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        push_random_text();
      end else begin
        push_noise();
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (drained);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d characters in %0d texts: %0d parsed to addresses, %0d rejected.",
             chars_taken, texts_checked, accepted_addrs, texts_checked - accepted_addrs);
    $display(
      "Included corner texts, a %0d-cycle output hold-off and drain pauses; %0d mismatches.",
      LongHold, mismatches);
    if (mismatches == 0 && addr_expect_q.size() == 0) begin
      $display("ipv4_dotted_text_parser_top verification clean");
    end else begin
      $display("ipv4_dotted_text_parser_top verification failed");
    end
    $finish;
  end

endmodule
